@@ rtl/core/nta_pkg.sv @@
package nta_pkg;

    // Function codes carried by an input word.
    localparam logic FUNC_HELLO = 1'b0;
    localparam logic FUNC_SWEEP = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_OWN_ADDRESS = 1'b0;
    localparam logic CFG_TIMEOUT     = 1'b1;

    // Reset value of the timeout register, in seconds.
    localparam logic [15:0] TIMEOUT_RESET = 16'd10;

    // Result status codes.
    typedef enum logic [2:0] {
        STATUS_IGNORED = 3'd0,
        STATUS_NEW     = 3'd1,
        STATUS_UPDATED = 3'd2,
        STATUS_FULL    = 3'd3,
        STATUS_EXPIRED = 3'd4,
        STATUS_DONE    = 3'd5
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [31:0] address;
        logic [15:0] seq;
        logic [31:0] heard;
    } entry_t;

    // One result word.
    typedef struct packed {
        status_t     status;
        logic [31:0] address;
        logic [15:0] seq;
        logic [3:0]  index;
        logic [4:0]  count;
        logic        last;
    } result_t;

endpackage

@@ rtl/core/neighbor_table_with_aging_core.sv @@
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  func, sender_address, sequence_req, now_seconds
// output    out        out_valid/out_stall  status, neighbor_address, neighbor_sequence,
//                                           entry_index, removed_count, last
// config    in         cfg_write            cfg_index, cfg_data
//
// Each word walks the entry memory one slot per cycle through its single read port. The
// final result is loaded when the scan ends (earlier when a hello finds its sender, and with
// no scan for a hello from the own address); the next word is taken once the sequencer is back
// in idle. Reset clears the valid bits and the control state at once; the entry memory
// itself is not cleared. While the output register is full and stalled, a sweep waits at
// each expired entry and any word waits at its final result; the next input word is taken
// while a finished result waits.
module neighbor_table_with_aging_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] sender_address,
    input  logic [15:0] sequence_req,
    input  logic [31:0] now_seconds,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] neighbor_address,
    output logic [15:0] neighbor_sequence,
    output logic [3:0]  entry_index,
    output logic [4:0]  removed_count,
    output logic        last
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);

    // Control state.
    nta_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic             out_valid_reg;
    logic [31:0]      own_address_reg;
    logic [15:0]      timeout_reg;

    // Latched input word and staged results.
    logic             func_reg;
    logic [31:0]      addr_reg;
    logic [15:0]      seq_reg;
    logic [31:0]      now_reg;
    nta_pkg::result_t res_reg, res_next;
    nta_pkg::result_t out_res_reg, out_res;
    logic             out_load;

    // Entry memory and its ports.
    nta_pkg::entry_t  mem [TABLE_ENTRIES];
    nta_pkg::entry_t  rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    nta_pkg::entry_t  wr_data;

    // Derived terms.
    logic             in_accept;
    logic             out_busy;
    logic             scan_done;
    logic             slot_valid;
    logic             hit;
    logic             expired;
    logic             advance;
    logic [31:0]      age;
    logic [15:0]      max_seq;
    logic [IDX_W+3:0] chk_idx_ext;
    logic [IDX_W+3:0] free_idx_ext;
    logic [CNT_W+4:0] removed_ext;

    // Handshake and scan conditions.
    assign in_stall     = (state_reg != nta_pkg::ST_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign out_busy     = out_valid_reg && out_stall;
    assign scan_done    = !chk_vld_reg && (issue_idx_reg == SCAN_END);
    assign slot_valid   = chk_vld_reg && valid_reg[chk_idx_reg];
    assign age          = now_reg - rd_data_reg.heard;
    assign hit          = slot_valid && (rd_data_reg.address == addr_reg);
    assign expired      = slot_valid && (age > {16'd0, timeout_reg});
    assign advance      = !((func_reg == nta_pkg::FUNC_SWEEP) && expired && out_busy);
    assign max_seq      = (seq_reg > rd_data_reg.seq) ? seq_reg : rd_data_reg.seq;
    assign chk_idx_ext  = {4'd0, chk_idx_reg};
    assign free_idx_ext = {4'd0, free_idx_reg};
    assign removed_ext  = {5'd0, removed_reg};
    assign rd_addr      = issue_idx_reg[IDX_W-1:0];

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nta_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (func == nta_pkg::FUNC_HELLO && sender_address == own_address_reg)
                        state_next = nta_pkg::ST_FINISH;
                    else
                        state_next = nta_pkg::ST_RUN;
                end
            end
            nta_pkg::ST_RUN:
            begin
                if (scan_done || (func_reg == nta_pkg::FUNC_HELLO && hit))
                    state_next = nta_pkg::ST_FINISH;
            end
            nta_pkg::ST_FINISH:
            begin
                if (!out_busy)
                    state_next = nta_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = nta_pkg::ST_IDLE;
            end
        endcase
    end

    // Scan, table update and result selection.
    always_comb
    begin
        issue_idx_next  = issue_idx_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        removed_next    = removed_reg;
        valid_next      = valid_reg;
        res_next        = res_reg;
        out_res         = res_reg;
        out_load        = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = chk_idx_reg;
        wr_data         = '{address: addr_reg, seq: max_seq, heard: now_reg};

        case (state_reg)
            nta_pkg::ST_IDLE:
            begin
                issue_idx_next  = '0;
                chk_vld_next    = 1'b0;
                free_found_next = 1'b0;
                removed_next    = '0;
                res_next        = '{status: nta_pkg::STATUS_IGNORED, address: 32'd0,
                                    seq: 16'd0, index: 4'd0, count: 5'd0, last: 1'b1};
            end
            nta_pkg::ST_RUN:
            begin
                // Issue the next read while the previous slot is checked.
                if (advance)
                begin
                    rd_en          = (issue_idx_reg != SCAN_END);
                    chk_vld_next   = rd_en;
                    chk_idx_next   = issue_idx_reg[IDX_W-1:0];
                    issue_idx_next = issue_idx_reg + CNT_W'(rd_en);
                end

                if (func_reg == nta_pkg::FUNC_HELLO)
                begin
                    // Remember the lowest free slot.
                    if (chk_vld_reg && !valid_reg[chk_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    if (hit)
                    begin
                        wr_en    = 1'b1;
                        res_next = '{status: nta_pkg::STATUS_UPDATED, address: addr_reg,
                                     seq: max_seq, index: chk_idx_ext[3:0], count: 5'd0,
                                     last: 1'b1};
                    end
                    else if (scan_done)
                    begin
                        if (free_found_reg)
                        begin
                            wr_en                   = 1'b1;
                            wr_addr                 = free_idx_reg;
                            wr_data                 = '{address: addr_reg, seq: seq_reg,
                                                        heard: now_reg};
                            valid_next[free_idx_reg] = 1'b1;
                            res_next = '{status: nta_pkg::STATUS_NEW, address: addr_reg,
                                         seq: seq_reg, index: free_idx_ext[3:0],
                                         count: 5'd0, last: 1'b1};
                        end
                        else
                        begin
                            res_next = '{status: nta_pkg::STATUS_FULL, address: 32'd0,
                                         seq: 16'd0, index: 4'd0, count: 5'd0, last: 1'b1};
                        end
                    end
                end
                else
                begin
                    // Report and drop an expired entry once the output is free.
                    if (expired && advance)
                    begin
                        valid_next[chk_idx_reg] = 1'b0;
                        removed_next            = removed_reg + 1'b1;
                        out_load                = 1'b1;
                        out_res = '{status: nta_pkg::STATUS_EXPIRED,
                                    address: rd_data_reg.address, seq: rd_data_reg.seq,
                                    index: chk_idx_ext[3:0], count: 5'd0, last: 1'b0};
                    end
                    if (scan_done)
                    begin
                        res_next = '{status: nta_pkg::STATUS_DONE, address: 32'd0,
                                     seq: 16'd0, index: 4'd0, count: removed_ext[4:0],
                                     last: 1'b1};
                    end
                end
            end
            nta_pkg::ST_FINISH:
            begin
                out_load = !out_busy;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= nta_pkg::ST_IDLE;
            issue_idx_reg   <= '0;
            chk_vld_reg     <= 1'b0;
            free_found_reg  <= 1'b0;
            removed_reg     <= '0;
            valid_reg       <= '0;
            out_valid_reg   <= 1'b0;
            own_address_reg <= 32'd0;
            timeout_reg     <= nta_pkg::TIMEOUT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            issue_idx_reg  <= issue_idx_next;
            chk_vld_reg    <= chk_vld_next;
            free_found_reg <= free_found_next;
            removed_reg    <= removed_next;
            valid_reg      <= valid_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_write)
            begin
                if (cfg_index == nta_pkg::CFG_OWN_ADDRESS)
                    own_address_reg <= cfg_data;
                else
                    timeout_reg <= cfg_data[15:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
        if (in_accept)
        begin
            func_reg <= func;
            addr_reg <= sender_address;
            seq_reg  <= sequence_req;
            now_reg  <= now_seconds;
        end
        if (out_load)
            out_res_reg <= out_res;
    end

    // Entry memory with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Output word.
    assign out_valid         = out_valid_reg;
    assign status            = out_res_reg.status;
    assign neighbor_address  = out_res_reg.address;
    assign neighbor_sequence = out_res_reg.seq;
    assign entry_index       = out_res_reg.index;
    assign removed_count     = out_res_reg.count;
    assign last              = out_res_reg.last;

endmodule
